// File: hdl/tss_pkg.sv
// Shared types and constants of the time-slice scheduler.
package tss_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int SLICE_W = 8;
   localparam int TICKS_W = 32;
   localparam int OUT_SLOT_W = 3;

   localparam logic [SLICE_W-1:0] SLICE_LENGTH_RESET = 8'd16;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_FORK = 2'd1;
   localparam logic [1:0] MODE_SLEEP = 2'd2;
   localparam logic [1:0] MODE_EXIT = 2'd3;

   typedef enum logic [2:0] {
      KIND_TICK = 3'd0,
      KIND_FORK = 3'd1,
      KIND_SLEEP = 3'd2,
      KIND_SLEEP_ZERO = 3'd3,
      KIND_EXIT = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [TICKS_W-1:0] sleep_ticks;
   } req_type;

   typedef struct packed {
      logic [OUT_SLOT_W-1:0] running_slot;
      logic switched;
      logic failed;
      logic [OUT_SLOT_W-1:0] new_slot;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [TICKS_W-1:0] ticks;
   } cmd_type;

endpackage

// File: hdl/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tss_front.sv
// Request intake: classifies each event and holds it in a two-entry command queue.
module tss_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  tss_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output tss_pkg::cmd_type cmd
);

   import tss_pkg::*;

   cmd_type    entry;
   cmd_type    buf_ff [2];
   cmd_type    buf_in [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push_ok;
   logic       pop_ok;

   always_comb begin
      entry.ticks = req_data.sleep_ticks;
      unique case (req_data.mode)
         MODE_TICK: begin
            entry.kind = KIND_TICK;
         end
         MODE_FORK: begin
            entry.kind = KIND_FORK;
         end
         MODE_SLEEP: begin
            if (req_data.sleep_ticks == '0) begin
               entry.kind = KIND_SLEEP_ZERO;
            end else begin
               entry.kind = KIND_SLEEP;
            end
         end
         MODE_EXIT: begin
            entry.kind = KIND_EXIT;
         end
         default: begin
            entry.kind = KIND_TICK;
         end
      endcase
   end

   assign full = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = buf_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok = cmd_pop && cmd_valid;

   always_comb begin
      buf_in = buf_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         buf_in[wr_ptr_ff] = entry;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop_ok) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

// File: hdl/tss_engine.sv
// Scheduling engine: slot table, sleep countdown scan, slot selection and response register.
module tss_engine #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   input  tss_pkg::cmd_type            cmd,
   input  logic [tss_pkg::SLICE_W-1:0] slice_length,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output tss_pkg::rsp_type            rsp_data
);

   import tss_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   cmd_kind_type         kind_ff, kind_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    idx_d_ff, idx_d_in;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [SLOT_W-1:0]    pick_ff, pick_in;
   logic [SLOT_W-1:0]    cur_ff, cur_in;
   logic [SLICE_W-1:0]   used_ff, used_in;
   logic [NUM_SLOTS-1:0] dead_ff, dead_in;
   logic [NUM_SLOTS-1:0] runnable_ff, runnable_in;
   logic [NUM_SLOTS-1:0] blocked_ff, blocked_in;
   logic                 out_full_ff, out_full_in;
   rsp_type              out_ff, out_in;

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [TICKS_W-1:0]   wr_data;
   logic [TICKS_W-1:0]   rd_data;
   logic                 wake;
   logic                 match;
   logic                 expire;
   logic                 run_en;
   logic [SLOT_W-1:0]    run_slot;
   logic                 res_switched;
   logic                 res_failed;
   logic [SLOT_W-1:0]    res_new;
   logic [SLOT_W+2:0]    cur_wide;
   logic [SLOT_W+2:0]    new_wide;

   tss_ram #(
      .WIDTH(TICKS_W),
      .DEPTH(NUM_SLOTS)
   ) u_sleep_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      idx_in = idx_ff;
      idx_d_in = idx_d_ff;
      pend_in = pend_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      cur_in = cur_ff;
      used_in = used_ff;
      dead_in = dead_ff;
      runnable_in = runnable_ff;
      blocked_in = blocked_ff;
      out_full_in = out_full_ff;
      out_in = out_ff;
      cmd_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = idx_d_ff;
      wr_data = rd_data - TICKS_W'(1);
      wake = 1'b0;
      match = 1'b0;
      expire = 1'b0;
      run_en = 1'b0;
      run_slot = '0;
      res_switched = 1'b0;
      res_failed = 1'b0;
      res_new = '0;
      cur_wide = '0;
      new_wide = '0;

      if (pend_ff) begin
         if (kind_ff == KIND_TICK && blocked_ff[idx_d_ff]) begin
            if (rd_data <= TICKS_W'(1)) begin
               wake = 1'b1;
               blocked_in[idx_d_ff] = 1'b0;
               runnable_in[idx_d_ff] = 1'b1;
            end else begin
               wr_en = 1'b1;
            end
         end
         if (kind_ff == KIND_FORK) begin
            match = dead_ff[idx_d_ff];
         end else begin
            match = runnable_ff[idx_d_ff] || wake;
         end
         if (match && !found_ff) begin
            found_in = 1'b1;
            pick_in = idx_d_ff;
         end
      end

      if (rsp_pop && out_full_ff) begin
         out_full_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               kind_in = cmd.kind;
               found_in = 1'b0;
               pick_in = '0;
               idx_in = FIRST_SLOT;
               if (cmd.kind == KIND_SLEEP) begin
                  blocked_in[cur_ff] = 1'b1;
                  wr_en = 1'b1;
                  wr_addr = cur_ff;
                  wr_data = cmd.ticks;
               end
               if (cmd.kind == KIND_EXIT) begin
                  dead_in[cur_ff] = 1'b1;
               end
               state_in = (cmd.kind == KIND_SLEEP_ZERO) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b1;
            idx_d_in = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + FIRST_SLOT;
            end
         end
         ST_DRAIN: begin
            pend_in = 1'b0;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_full_ff || rsp_pop) begin
               unique case (kind_ff)
                  KIND_TICK: begin
                     expire = (used_ff >= slice_length) || (cur_ff == '0);
                     if (expire && found_ff) begin
                        runnable_in[cur_ff] = 1'b1;
                        run_en = 1'b1;
                        run_slot = pick_ff;
                        res_switched = 1'b1;
                     end else if (expire) begin
                        used_in = (slice_length != '0) ? SLICE_W'(1) : '0;
                     end else begin
                        used_in = (used_ff < slice_length) ? used_ff + SLICE_W'(1)
                                                           : slice_length;
                     end
                  end
                  KIND_FORK: begin
                     if (found_ff) begin
                        dead_in[pick_ff] = 1'b0;
                        runnable_in[pick_ff] = 1'b1;
                        res_new = pick_ff;
                     end else begin
                        res_failed = 1'b1;
                     end
                  end
                  KIND_SLEEP, KIND_EXIT: begin
                     run_en = 1'b1;
                     if (found_ff) begin
                        run_slot = pick_ff;
                        res_switched = 1'b1;
                     end else begin
                        run_slot = '0;
                        res_switched = (cur_ff != '0);
                     end
                  end
                  KIND_SLEEP_ZERO: begin
                     res_failed = 1'b1;
                  end
                  default: begin
                     res_failed = 1'b0;
                  end
               endcase
               if (run_en) begin
                  cur_in = run_slot;
                  used_in = '0;
                  dead_in[run_slot] = 1'b0;
                  runnable_in[run_slot] = 1'b0;
                  blocked_in[run_slot] = 1'b0;
               end
               cur_wide = {3'b000, cur_in};
               new_wide = {3'b000, res_new};
               out_in.running_slot = cur_wide[OUT_SLOT_W-1:0];
               out_in.switched = res_switched;
               out_in.failed = res_failed;
               out_in.new_slot = new_wide[OUT_SLOT_W-1:0];
               out_full_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff <= idx_in;
      idx_d_ff <= idx_d_in;
      pick_ff <= pick_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff <= 1'b0;
         found_ff <= 1'b0;
         cur_ff <= '0;
         used_ff <= '0;
         dead_ff <= {{(NUM_SLOTS - 1){1'b1}}, 1'b0};
         runnable_ff <= '0;
         blocked_ff <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         found_ff <= found_in;
         cur_ff <= cur_in;
         used_ff <= used_in;
         dead_ff <= dead_in;
         runnable_ff <= runnable_in;
         blocked_ff <= blocked_in;
         out_full_ff <= out_full_in;
      end
   end

   assign rsp_empty = !out_full_ff;
   assign rsp_data = out_ff;

endmodule

// File: hdl/time_slice_scheduler_with_sleep.sv
// Top level of the round-robin time-slice scheduler with sleep, fork and exit.
// Each request is one scheduler event (tick, fork, sleep or exit) and yields one response
// naming the slot that runs afterwards. Requests enter a two-entry queue, so a few can be
// pushed while the engine works. The engine walks the slot table one slot per cycle through
// the read port of the sleep-count memory; a sleep of zero ticks skips the walk and is
// answered as failed. A finished response waits in an output register until popped while
// the engine already takes the next request. The slice length register sits at byte address 0
// and may be changed only while no request is in flight.
module time_slice_scheduler_with_sleep #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  tss_pkg::req_type               req_data,
   output logic                           empty,
   input  logic                           pop,
   output tss_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tss_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tss_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tss_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   import tss_pkg::*;

   logic [SLICE_W-1:0] slice_len_ff, slice_len_in;
   logic               csr_write;
   logic               cmd_valid;
   logic               cmd_pop;
   cmd_type            cmd;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = {{(CSR_DATA_W - SLICE_W){1'b0}}, slice_len_ff};

   always_comb begin
      slice_len_in = slice_len_ff;
      if (csr_write && paddr == '0) begin
         slice_len_in = pwdata[SLICE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_len_ff <= SLICE_LENGTH_RESET;
      end else begin
         slice_len_ff <= slice_len_in;
      end
   end

   tss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd      (cmd)
   );

   tss_engine #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd),
      .slice_length(slice_len_ff),
      .rsp_empty   (empty),
      .rsp_pop     (pop),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_fail_no_switch: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_data.failed && rsp_data.switched))
      else $error("A failed request reports a task switch.");

   a_fork_quiet: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.new_slot != '0) |-> (!rsp_data.failed && !rsp_data.switched))
      else $error("A successful fork reports a failure or a task switch.");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && paddr == '0)
      |=> (prdata[SLICE_W-1:0] == $past(pwdata[SLICE_W-1:0])))
      else $error("The slice length register did not take the written value.");
`endif

endmodule
